// ===== design/i2cmts_pkg.sv =====
// Shared types, codes and sizes for the I2C write-then-read sequencer.
package i2cmts_pkg;

   localparam int BUFFER_DEPTH = 16;
   localparam int BUF_AW = $clog2(BUFFER_DEPTH > 1 ? BUFFER_DEPTH : 2);
   localparam int POS_W = 5;
   localparam int LEN_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // request kinds
   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STATUS = 2'd2;

   // bus actions
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP = 2'd2;
   localparam logic [1:0] ACT_CONT = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_LEN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_LEN = 2'd3;

   // two-wire status codes
   localparam logic [7:0] ST_BUS_ERROR = 8'h00;
   localparam logic [7:0] ST_START = 8'h08;
   localparam logic [7:0] ST_REP_START = 8'h10;
   localparam logic [7:0] ST_MT_SLA_ACK = 8'h18;
   localparam logic [7:0] ST_MT_SLA_NACK = 8'h20;
   localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
   localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST = 8'h38;
   localparam logic [7:0] ST_MR_SLA_ACK = 8'h40;
   localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
   localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] status_code;
      logic [7:0] data_byte;
      logic [3:0] load_index;
   } item_type;

   typedef struct packed {
      logic [1:0] bus_action;
      logic       tx_valid;
      logic       tx_from_ram;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [3:0] rx_index;
      logic       transfer_done;
      logic       error_flag;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [BUF_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [BUF_AW-1:0] raddr;
   } ram_req_type;

endpackage

// ===== design/i2cmts_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module i2cmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/i2cmts_seq.sv =====
// Sequencer decision logic, transfer state and configuration registers.
module i2cmts_seq
   import i2cmts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  item_type              item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output result_type            decision,
   output ram_req_type           ram_req
);

   logic [7:0]       wr_addr_byte_ff;
   logic [7:0]       rd_addr_byte_ff;
   logic [LEN_W-1:0] wr_len_ff;
   logic [LEN_W-1:0] rd_len_ff;

   logic             busy_ff, busy_in;
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic [POS_W-1:0] rpos_ff, rpos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_addr_byte_ff <= 8'd0;
         rd_addr_byte_ff <= 8'd1;
         wr_len_ff       <= '0;
         rd_len_ff       <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WRITE_ADDR: wr_addr_byte_ff <= csr_wdata;
            CSR_READ_ADDR:  rd_addr_byte_ff <= csr_wdata;
            CSR_WRITE_LEN:  wr_len_ff <= csr_wdata[LEN_W-1:0];
            CSR_READ_LEN:   rd_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [POS_W-1:0] rpos_next;

      rpos_next = rpos_ff + 1'b1;
      decision  = '0;
      ram_req   = '0;
      busy_in   = busy_ff;
      wpos_in   = wpos_ff;
      rpos_in   = rpos_ff;

      ram_req.waddr = BUF_AW'(item.load_index);
      ram_req.wdata = item.data_byte;
      ram_req.raddr = '0;

      unique case (item.req_type)
         REQ_LOAD: begin
            ram_req.we = 32'(item.load_index) < 32'(BUFFER_DEPTH);
         end
         REQ_START: begin
            if (busy_ff) begin
               decision.error_flag = 1'b1;
            end else begin
               busy_in             = 1'b1;
               wpos_in             = '0;
               rpos_in             = '0;
               decision.bus_action = ACT_START;
            end
         end
         REQ_STATUS: begin
            unique case (item.status_code)
               ST_BUS_ERROR: begin
                  busy_in             = 1'b0;
                  decision.bus_action = ACT_STOP;
               end
               ST_START, ST_REP_START: begin
                  if (wpos_ff == '0 && wr_len_ff != '0) begin
                     decision.bus_action = ACT_CONT;
                     decision.tx_valid   = 1'b1;
                     decision.tx_byte    = wr_addr_byte_ff;
                  end else if (rpos_ff == '0 && rd_len_ff != '0) begin
                     decision.bus_action = ACT_CONT;
                     decision.tx_valid   = 1'b1;
                     decision.tx_byte    = rd_addr_byte_ff;
                  end else begin
                     decision.error_flag = 1'b1;
                  end
               end
               ST_MT_SLA_ACK: begin
                  // first data byte comes from slot zero of the buffer
                  decision.bus_action  = ACT_CONT;
                  decision.tx_valid    = 1'b1;
                  decision.tx_from_ram = 1'b1;
                  ram_req.re           = 1'b1;
                  wpos_in              = POS_W'(1);
               end
               ST_MT_SLA_NACK, ST_MT_DATA_NACK: begin
                  wpos_in             = '0;
                  rpos_in             = '0;
                  decision.bus_action = ACT_START;
               end
               ST_MT_DATA_ACK: begin
                  if (wpos_ff == wr_len_ff || 32'(wpos_ff) >= 32'(BUFFER_DEPTH)) begin
                     decision.bus_action = ACT_START;
                  end else begin
                     decision.bus_action  = ACT_CONT;
                     decision.tx_valid    = 1'b1;
                     decision.tx_from_ram = 1'b1;
                     ram_req.re           = 1'b1;
                     ram_req.raddr        = BUF_AW'(wpos_ff);
                     wpos_in              = wpos_ff + 1'b1;
                  end
               end
               ST_ARB_LOST: begin
                  wpos_in             = '0;
                  decision.bus_action = ACT_START;
               end
               ST_MR_SLA_ACK: begin
                  decision.bus_action = ACT_CONT;
               end
               ST_MR_SLA_NACK: begin
                  decision.bus_action = ACT_CONT;
                  decision.tx_valid   = 1'b1;
                  decision.tx_byte    = rd_addr_byte_ff;
               end
               ST_MR_DATA_ACK, ST_MR_DATA_NACK: begin
                  // deliver the byte unless it falls past the buffer
                  if (32'(rpos_ff) < 32'(BUFFER_DEPTH)) begin
                     decision.rx_valid = 1'b1;
                     decision.rx_byte  = item.data_byte;
                     decision.rx_index = rpos_ff[3:0];
                  end else begin
                     decision.error_flag = 1'b1;
                  end
                  rpos_in = rpos_next;
                  priority if (item.status_code == ST_MR_DATA_ACK) begin
                     if (rpos_next >= rd_len_ff) begin
                        busy_in                = 1'b0;
                        decision.bus_action    = ACT_STOP;
                        decision.transfer_done = 1'b1;
                     end else begin
                        decision.bus_action = ACT_CONT;
                     end
                  end else if (rpos_next != rd_len_ff) begin
                     wpos_in             = '0;
                     rpos_in             = '0;
                     decision.bus_action = ACT_START;
                  end else begin
                     busy_in                = 1'b0;
                     decision.bus_action    = ACT_STOP;
                     decision.transfer_done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // state moves only on an accepted transfer
      if (!accept) begin
         ram_req.we = 1'b0;
         ram_req.re = 1'b0;
         busy_in    = busy_ff;
         wpos_in    = wpos_ff;
         rpos_in    = rpos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wpos_ff <= '0;
         rpos_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         wpos_ff <= wpos_in;
         rpos_ff <= rpos_in;
      end
   end

endmodule

// ===== design/i2c_master_transfer_sequencer_core.sv =====
// Top level of the I2C write-then-read transfer sequencer.
//
// Requests arrive on the req_ channel (valid/stall): buffer loads, start
// requests and bus status events. Each accepted request yields exactly one
// response on the rsp_ channel with the bus action, an optional byte to send,
// an optional received byte with its index, and the done and error flags.
// Registers are to be written through csr_wr_en/csr_index/csr_wdata only
// while idle; the block does not enforce it. The decision and the write
// buffer RAM read are registered into stage one; the response register then
// loads from it, taking the byte to send from the RAM read data. Throughput
// is one request per cycle while req_stall is low. A stage register behind
// the response register lets one further request be taken while a response
// waits; req_stall rises once both are full and rsp_stall is high, and the
// waiting response holds unchanged. Reset clears busy, both positions, the
// pipeline and the registers, but sets the read address to 1; the write
// buffer is not cleared and a slot must be loaded before it is sent.
module i2c_master_transfer_sequencer_core
   import i2cmts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_status_code,
   input  logic [7:0]            req_data_byte,
   input  logic [3:0]            req_load_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_bus_action,
   output logic                  rsp_tx_valid,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_rx_valid,
   output logic [7:0]            rsp_rx_byte,
   output logic [3:0]            rsp_rx_index,
   output logic                  rsp_transfer_done,
   output logic                  rsp_error_flag,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   item_type    item;
   result_type  decision;
   ram_req_type ram_req;
   logic [7:0]  ram_rdata;
   logic        accept;
   logic        s1_advance;

   logic        s1_valid_ff, s1_valid_in;
   result_type  s1_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   assign item.req_type    = req_type;
   assign item.status_code = req_status_code;
   assign item.data_byte   = req_data_byte;
   assign item.load_index  = req_load_index;

   assign s1_advance = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept     = req_valid && !req_stall;

   i2cmts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .decision  (decision),
      .ram_req   (ram_req)
   );

   i2cmts_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_en   (ram_req.re),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_advance);
      out_valid_in = s1_advance || (out_valid_ff && rsp_stall);
      out_in = s1_ff;
      if (s1_ff.tx_from_ram) begin
         out_in.tx_byte = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // RAM data is only read on accept, so it holds while stage one waits
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= decision;
      end
      if (s1_advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_bus_action    = out_ff.bus_action;
   assign rsp_tx_valid      = out_ff.tx_valid;
   assign rsp_tx_byte       = out_ff.tx_byte;
   assign rsp_rx_valid      = out_ff.rx_valid;
   assign rsp_rx_byte       = out_ff.rx_byte;
   assign rsp_rx_index      = out_ff.rx_index;
   assign rsp_transfer_done = out_ff.transfer_done;
   assign rsp_error_flag    = out_ff.error_flag;

   a_stall_needs_waiting_rsp: assert property (
      @(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("request stalled with no response waiting");

   a_stage_holds: assert property (
      @(posedge clock) disable iff (reset) (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("stage one dropped a waiting result");

   a_ram_tx_flagged: assert property (
      @(posedge clock) disable iff (reset) (s1_valid_ff && s1_ff.tx_from_ram) |-> s1_ff.tx_valid)
      else $error("buffer byte selected without tx_valid");

   a_done_with_stop: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_transfer_done) |-> (rsp_bus_action == ACT_STOP))
      else $error("transfer_done without stop");

   a_tx_rx_exclusive: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> !(rsp_tx_valid && rsp_rx_valid))
      else $error("tx and rx flagged in one response");

endmodule
